[rtl/stl_pkg.sv]
// ----------------------------------------------------------------------------
// Smalltalk token lexer package
// Token kinds, error causes, lexing modes, character codes and the result
// record shared by the lexer modules and the testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package stl_pkg;

  localparam int MAX_RESULTS = 4;
  localparam int CNT_BITS    = 3;

  typedef enum logic [4:0] {
    TK_EOF       = 5'd0,
    TK_IDENT     = 5'd1,
    TK_STRING    = 5'd2,
    TK_INT       = 5'd3,
    TK_SYMBOL    = 5'd4,
    TK_LPAREN    = 5'd5,
    TK_RPAREN    = 5'd6,
    TK_LBRACKET  = 5'd7,
    TK_RBRACKET  = 5'd8,
    TK_PIPE      = 5'd9,
    TK_DOT       = 5'd10,
    TK_CARET     = 5'd11,
    TK_ASSIGN    = 5'd12,
    TK_COLON     = 5'd13,
    TK_SEPARATOR = 5'd14,
    TK_EQUALS    = 5'd15,
    TK_PLUS      = 5'd16,
    TK_MINUS     = 5'd17,
    TK_MULTIPLY  = 5'd18,
    TK_DIVIDE    = 5'd19,
    TK_LT        = 5'd20,
    TK_GT        = 5'd21,
    TK_HASH      = 5'd22,
    TK_NEWLINE   = 5'd23,
    TK_ERROR     = 5'd24
  } tok_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_UNEXPECTED   = 2'd1,
    ERR_OPEN_STRING  = 2'd2,
    ERR_OPEN_COMMENT = 2'd3
  } err_cause_t;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_IDENT     = 3'd1,
    MODE_INT       = 3'd2,
    MODE_STRING    = 3'd3,
    MODE_COMMENT   = 3'd4,
    MODE_SYM_FIRST = 3'd5,
    MODE_SYM_BODY  = 3'd6,
    MODE_SEP       = 3'd7
  } lex_mode_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  typedef struct packed {
    tok_kind_t   kind;
    err_cause_t  cause;
    logic [15:0] value;
    logic [31:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic [15:0] column;
    logic        last;
  } tok_t;

  typedef struct packed {
    tok_t [MAX_RESULTS-1:0] tok;
    logic [CNT_BITS-1:0]    count;
  } batch_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
  endfunction

  // Single-character tokens; TK_EOF means the byte is not one of them.
  function automatic tok_kind_t punct_kind(input logic [7:0] b);
    tok_kind_t k;
    case (b)
      8'h0A:   k = TK_NEWLINE;
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h5B:   k = TK_LBRACKET;
      8'h5D:   k = TK_RBRACKET;
      8'h7C:   k = TK_PIPE;
      8'h2E:   k = TK_DOT;
      8'h5E:   k = TK_CARET;
      8'h2B:   k = TK_PLUS;
      8'h2A:   k = TK_MULTIPLY;
      8'h2F:   k = TK_DIVIDE;
      8'h3C:   k = TK_LT;
      8'h3E:   k = TK_GT;
      8'h3D:   k = TK_EQUALS;
      default: k = TK_EOF;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[rtl/stl_if.sv]
// ----------------------------------------------------------------------------
// Smalltalk token lexer channels
// Valid/ready channels for source bytes and for tokens.
// ----------------------------------------------------------------------------
`default_nettype none

interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_text;

  modport source (output valid, output source_byte, output end_of_text, input ready);
  modport sink   (input valid, input source_byte, input end_of_text, output ready);
endinterface

interface stl_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         token_kind;
  logic [1:0]         error_cause;
  logic signed [15:0] token_value;
  logic [31:0]        text_start;
  logic [15:0]        text_length;
  logic [15:0]        line_number;
  logic [15:0]        column_number;
  logic               last_of_run;

  modport source (output valid, output token_kind, output error_cause, output token_value,
                  output text_start, output text_length, output line_number,
                  output column_number, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input error_cause, input token_value,
                  input text_start, input text_length, input line_number,
                  input column_number, input last_of_run, output ready);
endinterface

`default_nettype wire

[rtl/stl_scan.sv]
// ----------------------------------------------------------------------------
// Smalltalk token lexer scanner
// Lexing state registers and the per-byte logic that updates them and forms
// the tokens that one byte or end mark produces.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_scan #(
  parameter int POSITION_BITS = 32,
  parameter int LINE_BITS     = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          take,
  input  wire logic [7:0]    source_byte,
  input  wire logic          end_of_text,
  output stl_pkg::batch_t    batch
);

  stl_pkg::lex_mode_t       mode_r,   mode_nxt;
  logic [1:0]               dashes_r, dashes_nxt;
  logic                     colon_r,  colon_nxt;
  logic [LINE_BITS-1:0]     line_r,   line_nxt;
  logic [LINE_BITS-1:0]     col_r,    col_nxt;
  logic [POSITION_BITS-1:0] pos_r,    pos_nxt;
  logic [POSITION_BITS-1:0] tstart_r, tstart_nxt;
  logic [15:0]              tlen_r,   tlen_nxt;
  logic [15:0]              acc_r,    acc_nxt;
  logic                     neg_r,    neg_nxt;

  logic [LINE_BITS-1:0]     line_adv;
  logic [LINE_BITS-1:0]     col_adv;
  logic [LINE_BITS-1:0]     col_before;
  logic [POSITION_BITS-1:0] pos_adv;
  logic [2:0]               emit_cnt;
  logic                     do_begin;
  stl_pkg::tok_kind_t       pk;
  logic [15:0]              acc_times_ten;

  localparam logic [LINE_BITS-1:0] LC_MAX = '1;

  function automatic logic [15:0] clamp_lc(input logic [LINE_BITS-1:0] v);
    if (32'(v) > 32'h0000_FFFF) begin
      return 16'hFFFF;
    end
    return 16'(v);
  endfunction

  function automatic stl_pkg::tok_t mk_tok(
    input stl_pkg::tok_kind_t     kind,
    input stl_pkg::err_cause_t    cause,
    input logic [15:0]            value,
    input logic [POSITION_BITS-1:0] start,
    input logic [15:0]            len,
    input logic [LINE_BITS-1:0]   ln,
    input logic [LINE_BITS-1:0]   cl
  );
    stl_pkg::tok_t t;
    t.kind   = kind;
    t.cause  = cause;
    t.value  = value;
    t.start  = 32'(start);
    t.length = len;
    t.line   = clamp_lc(ln);
    t.column = clamp_lc(cl);
    t.last   = 1'b0;
    return t;
  endfunction

  assign pos_adv    = pos_r + 1'b1;
  assign line_adv   = (source_byte == stl_pkg::CH_NL && line_r != LC_MAX) ? line_r + 1'b1
                                                                          : line_r;
  assign col_adv    = (source_byte == stl_pkg::CH_NL) ? LINE_BITS'(1)
                    : (col_r != LC_MAX) ? col_r + 1'b1 : col_r;
  assign col_before = (col_r > LINE_BITS'(1)) ? col_r - 1'b1 : LINE_BITS'(1);
  assign pk         = stl_pkg::punct_kind(source_byte);
  assign acc_times_ten = (acc_r << 3) + (acc_r << 1) + {12'd0, source_byte[3:0]};

  // The byte is advanced over at most once per step, so the advanced
  // counters are formed once from the registered values.
  always_comb begin
    mode_nxt   = mode_r;
    dashes_nxt = dashes_r;
    colon_nxt  = colon_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    tlen_nxt   = tlen_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    batch      = '0;
    emit_cnt   = '0;
    do_begin   = 1'b0;

    if (end_of_text) begin
      if (colon_r) begin
        batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_COLON, stl_pkg::ERR_NONE, 16'd0,
                                          '0, 16'd0, line_r, col_r);
        emit_cnt = emit_cnt + 3'd1;
      end
      if (dashes_r == 2'd1) begin
        batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_MINUS, stl_pkg::ERR_NONE, 16'd0,
                                          '0, 16'd0, line_r, col_r);
        emit_cnt = emit_cnt + 3'd1;
      end
      if (dashes_r >= 2'd2) begin
        batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_MINUS, stl_pkg::ERR_NONE, 16'd0,
                                          '0, 16'd0, line_r, col_before);
        emit_cnt = emit_cnt + 3'd1;
        batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_MINUS, stl_pkg::ERR_NONE, 16'd0,
                                          '0, 16'd0, line_r, col_r);
        emit_cnt = emit_cnt + 3'd1;
      end
      case (mode_r)
        stl_pkg::MODE_IDENT: begin
          batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_IDENT, stl_pkg::ERR_NONE, 16'd0,
                                            tstart_r, tlen_r, line_r, col_r);
          emit_cnt = emit_cnt + 3'd1;
        end
        stl_pkg::MODE_INT: begin
          batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_INT, stl_pkg::ERR_NONE,
                                            neg_r ? 16'd0 - acc_r : acc_r,
                                            tstart_r, tlen_r, line_r, col_r);
          emit_cnt = emit_cnt + 3'd1;
        end
        stl_pkg::MODE_SYM_FIRST, stl_pkg::MODE_SYM_BODY: begin
          batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_SYMBOL, stl_pkg::ERR_NONE, 16'd0,
                                            tstart_r, tlen_r, line_r, col_r);
          emit_cnt = emit_cnt + 3'd1;
        end
        stl_pkg::MODE_SEP: begin
          batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_SEPARATOR, stl_pkg::ERR_NONE, 16'd0,
                                            '0, 16'd0, line_r, col_r);
          emit_cnt = emit_cnt + 3'd1;
        end
        stl_pkg::MODE_STRING: begin
          batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_ERROR, stl_pkg::ERR_OPEN_STRING,
                                            16'd0, '0, 16'd0, line_r, col_r);
          emit_cnt = emit_cnt + 3'd1;
        end
        stl_pkg::MODE_COMMENT: begin
          batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_ERROR, stl_pkg::ERR_OPEN_COMMENT,
                                            16'd0, '0, 16'd0, line_r, col_r);
          emit_cnt = emit_cnt + 3'd1;
        end
        default: begin
        end
      endcase
      colon_nxt  = 1'b0;
      dashes_nxt = 2'd0;
      mode_nxt   = stl_pkg::MODE_IDLE;
      batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_EOF, stl_pkg::ERR_NONE, 16'd0,
                                        '0, 16'd0, line_r, col_r);
      emit_cnt = emit_cnt + 3'd1;
    end else if (colon_r) begin
      colon_nxt = 1'b0;
      if (source_byte == stl_pkg::CH_EQUALS) begin
        line_nxt = line_adv;
        col_nxt  = col_adv;
        pos_nxt  = pos_adv;
        batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_ASSIGN, stl_pkg::ERR_NONE, 16'd0,
                                          '0, 16'd0, line_adv, col_adv);
        emit_cnt = emit_cnt + 3'd1;
      end else begin
        batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_COLON, stl_pkg::ERR_NONE, 16'd0,
                                          '0, 16'd0, line_r, col_r);
        emit_cnt = emit_cnt + 3'd1;
        do_begin = 1'b1;
      end
    end else if (dashes_r == 2'd1) begin
      dashes_nxt = 2'd0;
      if (source_byte == stl_pkg::CH_DASH) begin
        line_nxt   = line_adv;
        col_nxt    = col_adv;
        pos_nxt    = pos_adv;
        dashes_nxt = 2'd2;
      end else if (stl_pkg::is_digit(source_byte)) begin
        line_nxt = line_adv;
        col_nxt  = col_adv;
        pos_nxt  = pos_adv;
        mode_nxt = stl_pkg::MODE_INT;
        neg_nxt  = 1'b1;
        acc_nxt  = {12'd0, source_byte[3:0]};
        tlen_nxt = 16'd2;
      end else begin
        batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_MINUS, stl_pkg::ERR_NONE, 16'd0,
                                          '0, 16'd0, line_r, col_r);
        emit_cnt = emit_cnt + 3'd1;
        do_begin = 1'b1;
      end
    end else if (dashes_r >= 2'd2) begin
      dashes_nxt = 2'd0;
      if (source_byte == stl_pkg::CH_DASH) begin
        line_nxt = line_adv;
        col_nxt  = col_adv;
        pos_nxt  = pos_adv;
        mode_nxt = stl_pkg::MODE_SEP;
      end else begin
        batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_MINUS, stl_pkg::ERR_NONE, 16'd0,
                                          '0, 16'd0, line_r, col_before);
        emit_cnt = emit_cnt + 3'd1;
        if (stl_pkg::is_digit(source_byte)) begin
          tstart_nxt = tstart_r + 1'b1;
          line_nxt   = line_adv;
          col_nxt    = col_adv;
          pos_nxt    = pos_adv;
          mode_nxt   = stl_pkg::MODE_INT;
          neg_nxt    = 1'b1;
          acc_nxt    = {12'd0, source_byte[3:0]};
          tlen_nxt   = 16'd2;
        end else begin
          batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_MINUS, stl_pkg::ERR_NONE, 16'd0,
                                            '0, 16'd0, line_r, col_r);
          emit_cnt = emit_cnt + 3'd1;
          do_begin = 1'b1;
        end
      end
    end else begin
      case (mode_r)
        stl_pkg::MODE_IDENT: begin
          if (stl_pkg::is_word(source_byte)) begin
            line_nxt = line_adv;
            col_nxt  = col_adv;
            pos_nxt  = pos_adv;
            tlen_nxt = (tlen_r != 16'hFFFF) ? tlen_r + 16'd1 : tlen_r;
          end else begin
            batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_IDENT, stl_pkg::ERR_NONE, 16'd0,
                                              tstart_r, tlen_r, line_r, col_r);
            emit_cnt = emit_cnt + 3'd1;
            mode_nxt = stl_pkg::MODE_IDLE;
            do_begin = 1'b1;
          end
        end
        stl_pkg::MODE_INT: begin
          if (stl_pkg::is_digit(source_byte)) begin
            acc_nxt  = acc_times_ten;
            line_nxt = line_adv;
            col_nxt  = col_adv;
            pos_nxt  = pos_adv;
            tlen_nxt = (tlen_r != 16'hFFFF) ? tlen_r + 16'd1 : tlen_r;
          end else begin
            batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_INT, stl_pkg::ERR_NONE,
                                              neg_r ? 16'd0 - acc_r : acc_r,
                                              tstart_r, tlen_r, line_r, col_r);
            emit_cnt = emit_cnt + 3'd1;
            mode_nxt = stl_pkg::MODE_IDLE;
            do_begin = 1'b1;
          end
        end
        stl_pkg::MODE_STRING: begin
          line_nxt = line_adv;
          col_nxt  = col_adv;
          pos_nxt  = pos_adv;
          if (source_byte == stl_pkg::CH_QUOTE) begin
            batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_STRING, stl_pkg::ERR_NONE, 16'd0,
                                              tstart_r, tlen_r, line_adv, col_adv);
            emit_cnt = emit_cnt + 3'd1;
            mode_nxt = stl_pkg::MODE_IDLE;
          end else begin
            tlen_nxt = (tlen_r != 16'hFFFF) ? tlen_r + 16'd1 : tlen_r;
          end
        end
        stl_pkg::MODE_COMMENT: begin
          line_nxt = line_adv;
          col_nxt  = col_adv;
          pos_nxt  = pos_adv;
          if (source_byte == stl_pkg::CH_DQUOTE) begin
            mode_nxt = stl_pkg::MODE_IDLE;
          end
        end
        stl_pkg::MODE_SYM_FIRST, stl_pkg::MODE_SYM_BODY: begin
          if (mode_r == stl_pkg::MODE_SYM_FIRST && source_byte == stl_pkg::CH_LPAREN) begin
            line_nxt = line_adv;
            col_nxt  = col_adv;
            pos_nxt  = pos_adv;
            batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_HASH, stl_pkg::ERR_NONE, 16'd0,
                                              '0, 16'd0, line_adv, col_adv);
            emit_cnt = emit_cnt + 3'd1;
            mode_nxt = stl_pkg::MODE_IDLE;
          end else if (stl_pkg::is_word(source_byte)) begin
            mode_nxt = stl_pkg::MODE_SYM_BODY;
            line_nxt = line_adv;
            col_nxt  = col_adv;
            pos_nxt  = pos_adv;
            tlen_nxt = (tlen_r != 16'hFFFF) ? tlen_r + 16'd1 : tlen_r;
          end else begin
            batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_SYMBOL, stl_pkg::ERR_NONE, 16'd0,
                                              tstart_r, tlen_r, line_r, col_r);
            emit_cnt = emit_cnt + 3'd1;
            mode_nxt = stl_pkg::MODE_IDLE;
            do_begin = 1'b1;
          end
        end
        stl_pkg::MODE_SEP: begin
          if (source_byte == stl_pkg::CH_DASH) begin
            line_nxt = line_adv;
            col_nxt  = col_adv;
            pos_nxt  = pos_adv;
          end else begin
            batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_SEPARATOR, stl_pkg::ERR_NONE,
                                              16'd0, '0, 16'd0, line_r, col_r);
            emit_cnt = emit_cnt + 3'd1;
            mode_nxt = stl_pkg::MODE_IDLE;
            do_begin = 1'b1;
          end
        end
        default: begin
          mode_nxt = stl_pkg::MODE_IDLE;
          do_begin = 1'b1;
        end
      endcase
    end

    // Start of a new token from the idle mode; never follows an advance.
    if (do_begin) begin
      line_nxt = line_adv;
      col_nxt  = col_adv;
      pos_nxt  = pos_adv;
      case (source_byte)
        stl_pkg::CH_SPACE, stl_pkg::CH_CR, stl_pkg::CH_TAB: begin
        end
        stl_pkg::CH_COLON: begin
          colon_nxt = 1'b1;
        end
        stl_pkg::CH_DASH: begin
          tstart_nxt = pos_r;
          dashes_nxt = 2'd1;
        end
        stl_pkg::CH_QUOTE: begin
          tstart_nxt = pos_adv;
          tlen_nxt   = 16'd0;
          mode_nxt   = stl_pkg::MODE_STRING;
        end
        stl_pkg::CH_HASH: begin
          tstart_nxt = pos_adv;
          tlen_nxt   = 16'd0;
          mode_nxt   = stl_pkg::MODE_SYM_FIRST;
        end
        stl_pkg::CH_DQUOTE: begin
          mode_nxt = stl_pkg::MODE_COMMENT;
        end
        default: begin
          if (pk != stl_pkg::TK_EOF) begin
            batch.tok[emit_cnt[1:0]] = mk_tok(pk, stl_pkg::ERR_NONE, 16'd0,
                                              '0, 16'd0, line_adv, col_adv);
            emit_cnt = emit_cnt + 3'd1;
          end else begin
            tstart_nxt = pos_r;
            if (stl_pkg::is_alpha(source_byte) || source_byte == stl_pkg::CH_UNDER) begin
              mode_nxt = stl_pkg::MODE_IDENT;
              tlen_nxt = 16'd1;
            end else if (stl_pkg::is_digit(source_byte)) begin
              mode_nxt = stl_pkg::MODE_INT;
              neg_nxt  = 1'b0;
              acc_nxt  = {12'd0, source_byte[3:0]};
              tlen_nxt = 16'd1;
            end else begin
              batch.tok[emit_cnt[1:0]] = mk_tok(stl_pkg::TK_ERROR, stl_pkg::ERR_UNEXPECTED,
                                                16'd0, '0, 16'd0, line_adv, col_adv);
              emit_cnt = emit_cnt + 3'd1;
            end
          end
        end
      endcase
    end

    batch.count = emit_cnt;
    if (emit_cnt != 3'd0) begin
      batch.tok[2'(emit_cnt - 3'd1)].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= stl_pkg::MODE_IDLE;
      dashes_r <= 2'd0;
      colon_r  <= 1'b0;
      line_r   <= LINE_BITS'(1);
      col_r    <= LINE_BITS'(1);
      pos_r    <= '0;
      tstart_r <= '0;
      tlen_r   <= 16'd0;
      acc_r    <= 16'd0;
      neg_r    <= 1'b0;
    end else if (take) begin
      mode_r   <= mode_nxt;
      dashes_r <= dashes_nxt;
      colon_r  <= colon_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      tlen_r   <= tlen_nxt;
      acc_r    <= acc_nxt;
      neg_r    <= neg_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/stl_token_buffer.sv]
// ----------------------------------------------------------------------------
// Smalltalk token lexer result buffer
// Holds the tokens of one input transfer and hands them out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_token_buffer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire stl_pkg::batch_t  batch,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output stl_pkg::tok_t         out_tok
);

  stl_pkg::tok_t [stl_pkg::MAX_RESULTS-1:0] tok_r;
  logic [stl_pkg::CNT_BITS-1:0]             cnt_r;
  logic [stl_pkg::CNT_BITS-1:0]             rd_r;
  logic [stl_pkg::CNT_BITS-1:0]             remaining;

  assign remaining = cnt_r - rd_r;
  assign out_valid = (remaining != '0);
  assign in_ready  = (remaining == '0) ||
                     (remaining == stl_pkg::CNT_BITS'(1) && out_ready);
  assign out_tok   = tok_r[rd_r[1:0]];

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r <= batch.tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= '0;
    end else if (load) begin
      cnt_r <= batch.count;
      rd_r  <= '0;
    end else if (out_valid && out_ready) begin
      rd_r <= rd_r + 1'b1;
    end
  end

  a_rd_within_cnt : assert property (@(posedge clk) disable iff (!rst_n)
    rd_r <= cnt_r)
    else $error("read index passed the token count");

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= stl_pkg::CNT_BITS'(stl_pkg::MAX_RESULTS))
    else $error("token count exceeds the buffer");

  a_load_shows : assert property (@(posedge clk) disable iff (!rst_n)
    load && batch.count != '0 |=> out_valid)
    else $error("loaded tokens not presented");

  a_last_at_end : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tok.last |-> rd_r == cnt_r - 1'b1)
    else $error("last flag not on the final token of a transfer");

endmodule

`default_nettype wire

[rtl/smalltalk_token_lexer.sv]
// ----------------------------------------------------------------------------
// Smalltalk token lexer
// Streaming tokenizer: one source byte per input transfer, tokens out.
// ----------------------------------------------------------------------------
// Usage:
// The in_ch channel carries one source byte per transfer; end_of_text set
// flushes any pending token and produces an EOF token, and the byte is then
// ignored. Each input transfer yields zero to three tokens on out_ch, the
// last of them flagged by last_of_run. Tokens carry line and column just
// after their last character, and text position and length for identifiers,
// integers, strings and symbols.
// The tokens of a byte are presented in the cycle after its transfer.
// A byte yielding at most one token is taken every cycle while the receiver
// is ready; one yielding more holds in_ch.ready low until only its last
// token is left in the result buffer, which drains one token per cycle.
// When the receiver stalls, the current token is held and a new byte is
// taken only in the cycle its last pending token leaves. Reset clears the
// lexing mode and pending marks, sets line and column to one and the
// position to zero, and empties the result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module smalltalk_token_lexer #(
  parameter int POSITION_BITS = 32,
  parameter int LINE_BITS     = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  stl_in_if.sink    in_ch,
  stl_out_if.source out_ch
);

  stl_pkg::batch_t batch;
  stl_pkg::tok_t   out_tok;
  logic            take;
  logic            buf_ready;
  logic            buf_valid;

  assign take        = in_ch.valid && buf_ready;
  assign in_ch.ready = buf_ready;

  stl_scan #(
    .POSITION_BITS (POSITION_BITS),
    .LINE_BITS     (LINE_BITS)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .source_byte (in_ch.source_byte),
    .end_of_text (in_ch.end_of_text),
    .batch       (batch)
  );

  stl_token_buffer u_buffer (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .batch     (batch),
    .in_ready  (buf_ready),
    .out_valid (buf_valid),
    .out_ready (out_ch.ready),
    .out_tok   (out_tok)
  );

  assign out_ch.valid         = buf_valid;
  assign out_ch.token_kind    = out_tok.kind;
  assign out_ch.error_cause   = out_tok.cause;
  assign out_ch.token_value   = $signed(out_tok.value);
  assign out_ch.text_start    = out_tok.start;
  assign out_ch.text_length   = out_tok.length;
  assign out_ch.line_number   = out_tok.line;
  assign out_ch.column_number = out_tok.column;
  assign out_ch.last_of_run   = out_tok.last;

endmodule

`default_nettype wire

[test/tb_smalltalk_token_lexer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smalltalk token lexer testbench
// Feeds source bytes through the input channel and checks every token that
// leaves the output channel against a cycle-free lexer model kept in this
// file. A short directed table opens the run, then random token sequences
// with blanks, noise and end marks, and a random tail. Both channels idle at
// random and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------

module tb_smalltalk_token_lexer;

  localparam int          WATCHDOG_LIMIT  = 5000;
  localparam int          RANDOM_ITEMS    = 140;
  localparam int          TAIL_ITEMS      = 30;
  localparam int          HOLD_OFF_AT     = 70;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          DRAIN_CYCLES    = 12;
  localparam int          REPORT_LIMIT    = 10;
  localparam logic [15:0] COUNT_TOP       = 16'hFFFF;

  typedef struct packed {
    logic [7:0]          ch;
    logic                eot;
    logic                typed;
    stl_pkg::tok_kind_t  kind;
    stl_pkg::err_cause_t cause;
    logic [15:0]         line;
    logic [15:0]         column;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  stl_in_if  in_if ();
  stl_out_if out_if ();

  smalltalk_token_lexer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Lexer state as the block should hold it.
  stl_pkg::lex_mode_t lx_mode;
  logic [1:0]         lx_dashes;
  logic               lx_colon;
  logic [15:0]        lx_line;
  logic [15:0]        lx_col;
  logic [31:0]        lx_pos;
  logic [31:0]        lx_start;
  logic [15:0]        lx_len;
  logic [15:0]        lx_acc;
  logic               lx_neg;

  stl_pkg::tok_t run_tokens[$];
  stl_pkg::tok_t predicted_tokens[$];
  row_t          directed_rows[$];
  logic [8:0]    lexeme[$];

  int        items_sent = 0;
  int        accepted_bytes = 0;
  int        end_marks = 0;
  int        tokens_checked = 0;
  int        fault_count = 0;
  int        idle_cycles = 0;
  int        feed_calm = 0;
  bit        hold_off_done = 1'b0;
  bit [31:0] kinds_seen = '0;

  function automatic logic digit_ch(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic letter_ch(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic word_ch(input logic [7:0] b);
    return letter_ch(b) || digit_ch(b) || b == stl_pkg::CH_UNDER;
  endfunction

  function automatic void put_tok(input stl_pkg::tok_kind_t kind,
                                  input stl_pkg::err_cause_t cause,
                                  input logic [15:0] value, input logic [31:0] start,
                                  input logic [15:0] length, input logic [15:0] column);
    stl_pkg::tok_t t;
    if (run_tokens.size() < stl_pkg::MAX_RESULTS) begin
      t.kind   = kind;
      t.cause  = cause;
      t.value  = value;
      t.start  = start;
      t.length = length;
      t.line   = lx_line;
      t.column = column;
      t.last   = 1'b0;
      run_tokens.push_back(t);
    end
  endfunction

  function automatic void put_fixed(input stl_pkg::tok_kind_t kind,
                                    input logic [15:0] column);
    put_tok(kind, stl_pkg::ERR_NONE, 16'h0, 32'h0, 16'h0, column);
  endfunction

  function automatic void put_text(input stl_pkg::tok_kind_t kind);
    logic [15:0] v;
    v = 16'h0;
    if (kind == stl_pkg::TK_INT) v = lx_neg ? 16'h0 - lx_acc : lx_acc;
    put_tok(kind, stl_pkg::ERR_NONE, v, lx_start, lx_len, lx_col);
  endfunction

  function automatic logic [15:0] col_back();
    return (lx_col > 16'd1) ? lx_col - 16'd1 : 16'd1;
  endfunction

  function automatic void step_over(input logic [7:0] b);
    lx_pos = lx_pos + 32'd1;
    if (b == stl_pkg::CH_NL) begin
      if (lx_line != COUNT_TOP) lx_line = lx_line + 16'd1;
      lx_col = 16'd1;
    end else if (lx_col != COUNT_TOP) begin
      lx_col = lx_col + 16'd1;
    end
  endfunction

  function automatic void grow_text();
    if (lx_len != COUNT_TOP) lx_len = lx_len + 16'd1;
  endfunction

  function automatic void start_number(input logic [7:0] b, input logic neg,
                                       input logic [15:0] length);
    lx_mode = stl_pkg::MODE_INT;
    lx_neg  = neg;
    lx_acc  = {8'h00, b - 8'h30};
    lx_len  = length;
  endfunction

  function automatic void open_token(input logic [7:0] b);
    stl_pkg::tok_kind_t k;
    k = stl_pkg::TK_EOF;
    case (b)
      stl_pkg::CH_NL:     k = stl_pkg::TK_NEWLINE;
      stl_pkg::CH_LPAREN: k = stl_pkg::TK_LPAREN;
      ")":                k = stl_pkg::TK_RPAREN;
      "[":                k = stl_pkg::TK_LBRACKET;
      "]":                k = stl_pkg::TK_RBRACKET;
      "|":                k = stl_pkg::TK_PIPE;
      ".":                k = stl_pkg::TK_DOT;
      "^":                k = stl_pkg::TK_CARET;
      "+":                k = stl_pkg::TK_PLUS;
      "*":                k = stl_pkg::TK_MULTIPLY;
      "/":                k = stl_pkg::TK_DIVIDE;
      "<":                k = stl_pkg::TK_LT;
      ">":                k = stl_pkg::TK_GT;
      stl_pkg::CH_EQUALS: k = stl_pkg::TK_EQUALS;
      default:            k = stl_pkg::TK_EOF;
    endcase
    if (b == stl_pkg::CH_SPACE || b == stl_pkg::CH_CR || b == stl_pkg::CH_TAB) begin
      step_over(b);
    end else if (k != stl_pkg::TK_EOF) begin
      step_over(b);
      put_fixed(k, lx_col);
    end else if (b == stl_pkg::CH_COLON) begin
      step_over(b);
      lx_colon = 1'b1;
    end else if (b == stl_pkg::CH_DASH) begin
      lx_start = lx_pos;
      step_over(b);
      lx_dashes = 2'd1;
    end else if (b == stl_pkg::CH_QUOTE || b == stl_pkg::CH_HASH) begin
      step_over(b);
      lx_start = lx_pos;
      lx_len   = 16'd0;
      lx_mode  = (b == stl_pkg::CH_HASH) ? stl_pkg::MODE_SYM_FIRST : stl_pkg::MODE_STRING;
    end else if (b == stl_pkg::CH_DQUOTE) begin
      step_over(b);
      lx_mode = stl_pkg::MODE_COMMENT;
    end else begin
      lx_start = lx_pos;
      step_over(b);
      if (letter_ch(b) || b == stl_pkg::CH_UNDER) begin
        lx_mode = stl_pkg::MODE_IDENT;
        lx_len  = 16'd1;
      end else if (digit_ch(b)) begin
        start_number(b, 1'b0, 16'd1);
      end else begin
        put_tok(stl_pkg::TK_ERROR, stl_pkg::ERR_UNEXPECTED, 16'h0, 32'h0, 16'h0, lx_col);
      end
    end
  endfunction

  function automatic void close_text(input stl_pkg::tok_kind_t kind, input logic [7:0] b);
    put_text(kind);
    lx_mode = stl_pkg::MODE_IDLE;
    open_token(b);
  endfunction

  function automatic void feed_byte(input logic [7:0] b);
    if (lx_colon) begin
      lx_colon = 1'b0;
      if (b == stl_pkg::CH_EQUALS) begin
        step_over(b);
        put_fixed(stl_pkg::TK_ASSIGN, lx_col);
      end else begin
        put_fixed(stl_pkg::TK_COLON, lx_col);
        open_token(b);
      end
    end else if (lx_dashes == 2'd1) begin
      lx_dashes = 2'd0;
      if (b == stl_pkg::CH_DASH) begin
        step_over(b);
        lx_dashes = 2'd2;
      end else if (digit_ch(b)) begin
        step_over(b);
        start_number(b, 1'b1, 16'd2);
      end else begin
        put_fixed(stl_pkg::TK_MINUS, lx_col);
        open_token(b);
      end
    end else if (lx_dashes >= 2'd2) begin
      lx_dashes = 2'd0;
      if (b == stl_pkg::CH_DASH) begin
        step_over(b);
        lx_mode = stl_pkg::MODE_SEP;
      end else begin
        put_fixed(stl_pkg::TK_MINUS, col_back());
        if (digit_ch(b)) begin
          lx_start = lx_start + 32'd1;
          step_over(b);
          start_number(b, 1'b1, 16'd2);
        end else begin
          put_fixed(stl_pkg::TK_MINUS, lx_col);
          open_token(b);
        end
      end
    end else begin
      case (lx_mode)
        stl_pkg::MODE_IDENT: begin
          if (word_ch(b)) begin
            step_over(b);
            grow_text();
          end else begin
            close_text(stl_pkg::TK_IDENT, b);
          end
        end
        stl_pkg::MODE_INT: begin
          if (digit_ch(b)) begin
            lx_acc = lx_acc * 16'd10 + {8'h00, b - 8'h30};
            step_over(b);
            grow_text();
          end else begin
            close_text(stl_pkg::TK_INT, b);
          end
        end
        stl_pkg::MODE_STRING: begin
          step_over(b);
          if (b == stl_pkg::CH_QUOTE) begin
            put_text(stl_pkg::TK_STRING);
            lx_mode = stl_pkg::MODE_IDLE;
          end else begin
            grow_text();
          end
        end
        stl_pkg::MODE_COMMENT: begin
          step_over(b);
          if (b == stl_pkg::CH_DQUOTE) lx_mode = stl_pkg::MODE_IDLE;
        end
        stl_pkg::MODE_SYM_FIRST, stl_pkg::MODE_SYM_BODY: begin
          if (lx_mode == stl_pkg::MODE_SYM_FIRST && b == stl_pkg::CH_LPAREN) begin
            step_over(b);
            put_fixed(stl_pkg::TK_HASH, lx_col);
            lx_mode = stl_pkg::MODE_IDLE;
          end else begin
            lx_mode = stl_pkg::MODE_SYM_BODY;
            if (word_ch(b)) begin
              step_over(b);
              grow_text();
            end else begin
              close_text(stl_pkg::TK_SYMBOL, b);
            end
          end
        end
        stl_pkg::MODE_SEP: begin
          if (b == stl_pkg::CH_DASH) begin
            step_over(b);
          end else begin
            put_fixed(stl_pkg::TK_SEPARATOR, lx_col);
            lx_mode = stl_pkg::MODE_IDLE;
            open_token(b);
          end
        end
        default: begin
          lx_mode = stl_pkg::MODE_IDLE;
          open_token(b);
        end
      endcase
    end
  endfunction

  function automatic void flush_text();
    if (lx_colon) put_fixed(stl_pkg::TK_COLON, lx_col);
    if (lx_dashes == 2'd1) put_fixed(stl_pkg::TK_MINUS, lx_col);
    if (lx_dashes >= 2'd2) begin
      put_fixed(stl_pkg::TK_MINUS, col_back());
      put_fixed(stl_pkg::TK_MINUS, lx_col);
    end
    case (lx_mode)
      stl_pkg::MODE_IDENT: put_text(stl_pkg::TK_IDENT);
      stl_pkg::MODE_INT:   put_text(stl_pkg::TK_INT);
      stl_pkg::MODE_SYM_FIRST, stl_pkg::MODE_SYM_BODY: put_text(stl_pkg::TK_SYMBOL);
      stl_pkg::MODE_SEP:   put_fixed(stl_pkg::TK_SEPARATOR, lx_col);
      stl_pkg::MODE_STRING:
        put_tok(stl_pkg::TK_ERROR, stl_pkg::ERR_OPEN_STRING, 16'h0, 32'h0, 16'h0, lx_col);
      stl_pkg::MODE_COMMENT:
        put_tok(stl_pkg::TK_ERROR, stl_pkg::ERR_OPEN_COMMENT, 16'h0, 32'h0, 16'h0, lx_col);
      default: ;
    endcase
    lx_colon  = 1'b0;
    lx_dashes = 2'd0;
    lx_mode   = stl_pkg::MODE_IDLE;
    put_fixed(stl_pkg::TK_EOF, lx_col);
  endfunction

  function automatic void lex_step(input logic [7:0] b, input logic eot);
    run_tokens.delete();
    if (eot) flush_text();
    else feed_byte(b);
    if (run_tokens.size() > 0) run_tokens[run_tokens.size() - 1].last = 1'b1;
  endfunction

  task automatic log_fault(input string what, input stl_pkg::tok_t want,
                           input stl_pkg::tok_t seen);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) begin
      $display("%0t: %s at token %0d (expected / actual)", $time, what, tokens_checked);
      $display("  kind %0d / %0d  cause %0d / %0d  value %0d / %0d  last %0b / %0b",
               want.kind, seen.kind, want.cause, seen.cause,
               $signed(want.value), $signed(seen.value), want.last, seen.last);
      $display("  start %0d / %0d  length %0d / %0d  line %0d / %0d  column %0d / %0d",
               want.start, seen.start, want.length, seen.length,
               want.line, seen.line, want.column, seen.column);
    end
  endtask

  always @(posedge clk) begin : monitor
    stl_pkg::tok_t seen;
    stl_pkg::tok_t want;
    row_t          row;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        lex_step(in_if.source_byte, in_if.end_of_text);
        if (accepted_bytes < directed_rows.size()) begin
          row = directed_rows[accepted_bytes];
          if (row.typed) begin
            want.kind   = row.kind;
            want.cause  = row.cause;
            want.value  = 16'h0;
            want.start  = 32'h0;
            want.length = 16'h0;
            want.line   = row.line;
            want.column = row.column;
            want.last   = 1'b1;
            run_tokens.delete();
            run_tokens.push_back(want);
          end
        end
        foreach (run_tokens[i]) predicted_tokens.push_back(run_tokens[i]);
        if (in_if.end_of_text) end_marks++;
        accepted_bytes++;
      end
      if (out_if.valid && out_if.ready) begin
        seen.kind   = stl_pkg::tok_kind_t'(out_if.token_kind);
        seen.cause  = stl_pkg::err_cause_t'(out_if.error_cause);
        seen.value  = out_if.token_value;
        seen.start  = out_if.text_start;
        seen.length = out_if.text_length;
        seen.line   = out_if.line_number;
        seen.column = out_if.column_number;
        seen.last   = out_if.last_of_run;
        kinds_seen[out_if.token_kind] = 1'b1;
        if (predicted_tokens.size() == 0) begin
          log_fault("token with none expected", '0, seen);
        end else begin
          want = predicted_tokens.pop_front();
          if (seen !== want) log_fault("token mismatch", want, seen);
        end
        tokens_checked++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d tokens still expected",
               $time, idle_cycles, predicted_tokens.size());
      $display("smalltalk_token_lexer verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else return $urandom_range(20, 40);
  endfunction

  initial begin : receiver
    int n;
    int calm;
    calm = 0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_off_done && accepted_bytes >= HOLD_OFF_AT) begin
        hold_off_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (calm > 0) begin
        calm--;
        out_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = pick_gap();
        if ($urandom_range(0, 19) == 0) calm = 40;
        if (n > 0) begin
          out_if.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [7:0] ch, input logic eot);
    int gap;
    gap = 0;
    if (feed_calm > 0) begin
      feed_calm--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 24) == 0) feed_calm = 30;
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.source_byte <= ch;
    in_if.end_of_text <= eot;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic add_row(input logic [7:0] ch, input logic eot, input logic typed,
                         input stl_pkg::tok_kind_t kind, input stl_pkg::err_cause_t cause,
                         input logic [15:0] line, input logic [15:0] column);
    row_t row;
    row.ch     = ch;
    row.eot    = eot;
    row.typed  = typed;
    row.kind   = kind;
    row.cause  = cause;
    row.line   = line;
    row.column = column;
    directed_rows.push_back(row);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_row(s[i], 1'b0, 1'b0, stl_pkg::TK_EOF, stl_pkg::ERR_NONE, 16'd0, 16'd0);
    end
  endtask

  function automatic void stage_byte(input logic [7:0] ch);
    lexeme.push_back({1'b0, ch});
  endfunction

  function automatic logic [7:0] word_pick(input bit lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    else if (r < 52) return 8'("A" + r - 26);
    else if (r == 52) return stl_pkg::CH_UNDER;
    else return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] text_pick(input logic [7:0] closer);
    logic [7:0] ch;
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) ch = stl_pkg::CH_NL;
    else if (r == 1) ch = 8'($urandom_range(0, 255));
    else ch = 8'($urandom_range(32, 126));
    return (ch == closer) ? "x" : ch;
  endfunction

  // One token's worth of source text, mostly well formed, sometimes broken.
  task automatic queue_lexeme();
    int r;
    int n;
    logic [7:0] closer;
    r = $urandom_range(0, 99);
    closer = (r < 41) ? stl_pkg::CH_QUOTE : stl_pkg::CH_DQUOTE;
    if (r < 15) begin
      stage_byte(word_pick(1'b1));
      repeat ($urandom_range(0, 7)) stage_byte(word_pick(1'b0));
    end else if (r < 27 || r < 33) begin
      if (r >= 27) stage_byte(stl_pkg::CH_DASH);
      repeat ($urandom_range(1, 6)) stage_byte(8'("0" + $urandom_range(0, 9)));
    end else if (r < 41 || r < 46) begin
      stage_byte(closer);
      repeat ($urandom_range(0, 6)) stage_byte(text_pick(closer));
      if ($urandom_range(0, 9) != 0) stage_byte(closer);
    end else if (r < 52) begin
      stage_byte(stl_pkg::CH_HASH);
      repeat ($urandom_range(0, 5)) stage_byte(word_pick(1'b0));
    end else if (r < 55) begin
      stage_byte(stl_pkg::CH_HASH);
      stage_byte(stl_pkg::CH_LPAREN);
    end else if (r < 67) begin
      case ($urandom_range(0, 13))
        0:       stage_byte(stl_pkg::CH_NL);
        1:       stage_byte(stl_pkg::CH_LPAREN);
        2:       stage_byte(")");
        3:       stage_byte("[");
        4:       stage_byte("]");
        5:       stage_byte("|");
        6:       stage_byte(".");
        7:       stage_byte("^");
        8:       stage_byte("+");
        9:       stage_byte("*");
        10:      stage_byte("/");
        11:      stage_byte("<");
        12:      stage_byte(">");
        default: stage_byte(stl_pkg::CH_EQUALS);
      endcase
    end else if (r < 72) begin
      stage_byte(stl_pkg::CH_COLON);
      stage_byte(stl_pkg::CH_EQUALS);
    end else if (r < 75) begin
      stage_byte(stl_pkg::CH_COLON);
    end else if (r < 80) begin
      repeat ($urandom_range(3, 6)) stage_byte(stl_pkg::CH_DASH);
    end else if (r < 83) begin
      repeat ($urandom_range(1, 2)) stage_byte(stl_pkg::CH_DASH);
    end else if (r < 91) begin
      stage_byte(stl_pkg::CH_NL);
    end else if (r < 96) begin
      stage_byte(8'($urandom_range(0, 255)));
    end else begin
      lexeme.push_back({1'b1, 8'($urandom_range(0, 255))});
    end
    if ($urandom_range(0, 9) < 4) begin
      n = $urandom_range(0, 2);
      stage_byte(n == 0 ? stl_pkg::CH_SPACE : (n == 1 ? stl_pkg::CH_TAB : stl_pkg::CH_CR));
    end
  endtask

  task automatic send_lexemes(input int target);
    int sent;
    logic [8:0] item;
    sent = 0;
    while (sent < target) begin
      queue_lexeme();
      while (lexeme.size() != 0) begin
        item = lexeme.pop_front();
        send_item(item[7:0], item[8]);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    lx_mode   = stl_pkg::MODE_IDLE;
    lx_dashes = 2'd0;
    lx_colon  = 1'b0;
    lx_line   = 16'd1;
    lx_col    = 16'd1;
    lx_pos    = 32'd0;
    lx_start  = 32'd0;
    lx_len    = 16'd0;
    lx_acc    = 16'd0;
    lx_neg    = 1'b0;
    in_if.valid       <= 1'b0;
    in_if.source_byte <= 8'h00;
    in_if.end_of_text <= 1'b0;

    add_row(stl_pkg::CH_LPAREN, 1'b0, 1'b1, stl_pkg::TK_LPAREN, stl_pkg::ERR_NONE,
            16'd1, 16'd2);
    add_row(8'h00, 1'b0, 1'b1, stl_pkg::TK_ERROR, stl_pkg::ERR_UNEXPECTED, 16'd1, 16'd3);
    add_row(8'hFF, 1'b0, 1'b1, stl_pkg::TK_ERROR, stl_pkg::ERR_UNEXPECTED, 16'd1, 16'd4);
    add_text("a_9:=--7--+---#(#:'\n'\"");
    add_row(8'h00, 1'b1, 1'b0, stl_pkg::TK_EOF, stl_pkg::ERR_NONE, 16'd0, 16'd0);
    add_text("'");
    add_row(8'hFF, 1'b1, 1'b0, stl_pkg::TK_EOF, stl_pkg::ERR_NONE, 16'd0, 16'd0);
    add_text("--");
    add_row(8'h00, 1'b1, 1'b0, stl_pkg::TK_EOF, stl_pkg::ERR_NONE, 16'd0, 16'd0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_item(directed_rows[i].ch, directed_rows[i].eot);
    send_lexemes(RANDOM_ITEMS);
    send_lexemes(TAIL_ITEMS);
    send_item(8'h00, 1'b1);
    in_if.valid <= 1'b0;

    while (accepted_bytes != items_sent || predicted_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d source transfers with %0d end marks; %0d tokens checked, %0d faults.",
             accepted_bytes, end_marks, tokens_checked, fault_count);
    $display("Saw %0d of 25 token kinds; the source text ended on line %0d.",
             $countones(kinds_seen), lx_line);
    if (fault_count == 0 && predicted_tokens.size() == 0) begin
      $display("smalltalk_token_lexer verification clean");
    end else begin
      $display("smalltalk_token_lexer verification failed");
    end
    $finish;
  end

endmodule
